FILE: hdl/isort_pkg.sv
`timescale 1ns / 1ps
package isort_pkg;

	// capacity of the sorted store
	localparam int DEPTH = 16;
	// fill count holds 0 to DEPTH
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// commands from controller to datapath
	typedef struct packed {
		logic insert;
		logic pop;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic fill_one;
	} sts_t;

endpackage

FILE: hdl/isort_datapath.sv
`timescale 1ns / 1ps
module isort_datapath import isort_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cmd_t  cmd,
	output sts_t  sts,
	input  data_t value,
	output data_t sorted_value,
	output logic  last_result,
	output logic  overflow
);

	data_t store_q [DEPTH];
	cnt_t fill_q;
	logic drop_q;
	logic full;
	logic [DEPTH-1:0] gt;

	assign full = (fill_q == CNT_W'(DEPTH));

	// per entry: empty slot or stored value strictly greater than the new one
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			gt[i] = (CNT_W'(i) >= fill_q) || (store_q[i] > value);
		end
	end

	// store cells: insert with shift up, or shift down on emit
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (cmd.insert && !full) begin
				if (gt[i]) begin
					if (i == 0) begin
						store_q[i] <= value;
					end else if (gt[(i == 0) ? 0 : i-1]) begin
						store_q[i] <= store_q[(i == 0) ? 0 : i-1];
					end else begin
						store_q[i] <= value;
					end
				end
			end else if (cmd.pop) begin
				if (i < DEPTH - 1) begin
					store_q[i] <= store_q[(i < DEPTH - 1) ? i+1 : i];
				end
			end
		end
	end

	// fill count and dropped flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			drop_q <= 1'b0;
		end else if (cmd.insert) begin
			if (full) begin
				drop_q <= 1'b1;
			end else begin
				fill_q <= fill_q + CNT_W'(1);
			end
		end else if (cmd.pop) begin
			fill_q <= fill_q - CNT_W'(1);
			if (fill_q == CNT_W'(1)) begin
				drop_q <= 1'b0;
			end
		end
	end

	assign sts.fill_one = (fill_q == CNT_W'(1));
	assign sorted_value = store_q[0];
	assign last_result  = sts.fill_one;
	assign overflow     = drop_q;

endmodule

FILE: hdl/isort_ctrl.sv
`timescale 1ns / 1ps
module isort_ctrl import isort_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic last_item,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic {
		ST_COLLECT,
		ST_EMIT
	} state_t;

	state_t state_q;

	assign in_ready   = (state_q == ST_COLLECT);
	assign out_valid  = (state_q == ST_EMIT);
	assign cmd.insert = in_valid && in_ready;
	assign cmd.pop    = out_valid && out_ready;

	// collect items until the last one, then emit the whole set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
		end else begin
			unique case (state_q)
				ST_COLLECT: begin
					if (cmd.insert && last_item) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (cmd.pop && sts.fill_one) begin
						state_q <= ST_COLLECT;
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end

endmodule

FILE: hdl/insertion_sorter.sv
`timescale 1ns / 1ps
// stable ascending sorter for sets of signed 32-bit values, up to DEPTH (16)
// input channel: value, last_item with in_valid / in_ready; one item is taken
// per cycle while collecting, each inserted by a row of parallel compare
// cells that shift greater entries up one place
// an item arriving with the store full is dropped and flags overflow
// the item with last_item set ends the set: from the next cycle the output
// channel (sorted_value, last_result, overflow with out_valid / out_ready)
// presents the set smallest first, one item per cycle while out_ready is high;
// last_result marks the final item, overflow is the same on every item of
// the set
// while emitting, in_ready is low; after the final item is taken the block
// is ready for a new set in the next cycle
// a stalled receiver holds the current item; the store shifts only on accept
// reset empties the store and clears overflow; no clearing pass is needed
module insertion_sorter import isort_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  data_t value,
	input  logic  last_item,
	output logic  out_valid,
	input  logic  out_ready,
	output data_t sorted_value,
	output logic  last_result,
	output logic  overflow
);

	cmd_t cmd;
	sts_t sts;

	// sequencing
	isort_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_item (last_item),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// sorted store
	isort_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.value        (value),
		.sorted_value (sorted_value),
		.last_result  (last_result),
		.overflow     (overflow)
	);

	// collecting and emitting never overlap
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> !in_ready)
		else $error("output valid while accepting input");

	// final item returns the block to collecting
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && last_result) |=> (in_ready && !out_valid))
		else $error("block not ready after final item");

	// an item that is not last yields no result
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !last_item) |=> !out_valid)
		else $error("result after non-last item");

	// emission continues until the final item
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_result) |=> out_valid)
		else $error("emission stopped early");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
	import isort_pkg::*;

	localparam int LIMIT = 200000;
	localparam int RAND_ITEMS = 300;
	localparam data_t VMAX = 32'h7fff_ffff;
	localparam data_t VMIN = 32'h8000_0000;

	// one sorted item as it leaves the block
	typedef struct {
		data_t val;
		logic  fin;
		logic  ovf;
	} sorted_item_t;

	// one directed row: reps items val, val+step, ...; last marks the final one
	typedef struct {
		data_t val;
		int    step;
		int    reps;
		logic  fin;
		logic  typed;
		data_t exp_val;
		logic  exp_ovf;
	} plan_row_t;

	typedef enum int {MIX_WIDE, MIX_NARROW, MIX_EDGE, MIX_SPARSE} value_mix_e;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_ready;
	data_t value = '0;
	logic  last_item = 1'b0;
	logic  out_valid;
	logic  out_ready = 1'b0;
	data_t sorted_value;
	logic  last_result;
	logic  overflow;

	int errors = 0;
	int cycles = 0;
	bit calm = 1'b0;

	// mirror of the sorted store
	data_t held [DEPTH];
	int    held_n = 0;
	bit    held_drop = 1'b0;
	sorted_item_t pending [$];

	plan_row_t plan [15] = '{
		'{VMAX, 0, 1, 1'b1, 1'b1, VMAX, 1'b0},
		'{VMIN, 0, 1, 1'b1, 1'b1, VMIN, 1'b0},
		'{0, 0, 1, 1'b1, 1'b1, 0, 1'b0},
		'{5, 0, 1, 1'b0, 1'b0, 0, 1'b0},
		'{VMIN, 0, 1, 1'b0, 1'b0, 0, 1'b0},
		'{5, 0, 1, 1'b0, 1'b0, 0, 1'b0},
		'{VMAX, 0, 1, 1'b0, 1'b0, 0, 1'b0},
		'{-3, 0, 1, 1'b1, 1'b0, 0, 1'b0},
		// descending fill makes every insert shift the whole store
		'{1000, -7, 16, 1'b0, 1'b0, 0, 1'b0},
		// store full: plain item dropped, then last item dropped too
		'{-999, 0, 1, 1'b0, 1'b0, 0, 1'b0},
		'{-1, 0, 1, 1'b1, 1'b0, 0, 1'b0},
		// overflow must not carry into the next set
		'{42, 0, 1, 1'b1, 1'b1, 42, 1'b0},
		'{-1, 0, 1, 1'b1, 1'b1, -1, 1'b0},
		'{2, 0, 1, 1'b0, 1'b0, 0, 1'b0},
		'{1, 0, 1, 1'b1, 1'b0, 0, 1'b0}
	};

	insertion_sorter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value(value),
		.last_item(last_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sorted_value(sorted_value),
		.last_result(last_result),
		.overflow(overflow)
	);

	always #1 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
	endtask

	// insert one value into the mirror; a last item dumps the sorted set
	task automatic sort_step(input data_t v, input logic fin);
		int pos;
		sorted_item_t r;
		if (held_n >= DEPTH) begin
			held_drop = 1'b1;
		end else begin
			pos = held_n;
			while (pos > 0 && held[pos-1] > v) begin
				held[pos] = held[pos-1];
				pos--;
			end
			held[pos] = v;
			held_n++;
		end
		if (fin) begin
			for (int k = 0; k < held_n; k++) begin
				r.val = held[k];
				r.fin = (k == held_n - 1);
				r.ovf = held_drop;
				pending.push_back(r);
			end
			held_n = 0;
			held_drop = 1'b0;
		end
	endtask

	// offer one item, starting just after a falling edge, with random gaps
	task automatic push_item(input data_t v, input logic fin);
		while (!calm && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		last_item <= fin;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	function automatic data_t pick_value(input value_mix_e mix);
		data_t v;
		case (mix)
			MIX_NARROW: v = int'($urandom_range(16)) - 8;
			MIX_EDGE: begin
				case ($urandom_range(6))
					0: v = VMIN;
					1: v = VMIN + 1;
					2: v = -1;
					3: v = 0;
					4: v = 1;
					5: v = VMAX - 1;
					default: v = VMAX;
				endcase
			end
			MIX_SPARSE: v = $urandom & 32'h8000_00ff;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// receiver stalls
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_ready <= calm || ($urandom_range(99) >= 19);
		end
	end

	// result checker
	always @(posedge clk) begin
		sorted_item_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending.size() == 0) begin
				report("unexpected item", sorted_value, 'x);
			end else begin
				e = pending.pop_front();
				if (sorted_value !== e.val)
					report("sorted_value", sorted_value, e.val);
				if (last_result !== e.fin)
					report("last_result", last_result, e.fin);
				if (overflow !== e.ovf)
					report("overflow", overflow, e.ovf);
			end
		end
	end

	initial begin
		int sent;
		int len;
		int sets;
		value_mix_e mix;
		sorted_item_t typed_res;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		foreach (plan[i]) begin
			for (int j = 0; j < plan[i].reps; j++) begin
				push_item(plan[i].val + j * plan[i].step, plan[i].fin && j == plan[i].reps - 1);
				sort_step(plan[i].val + j * plan[i].step, plan[i].fin && j == plan[i].reps - 1);
			end
			if (plan[i].typed) begin
				pending.delete(pending.size() - 1);
				typed_res.val = plan[i].exp_val;
				typed_res.fin = 1'b1;
				typed_res.ovf = plan[i].exp_ovf;
				pending.push_back(typed_res);
			end
		end

		// random sets, mostly within capacity, some overflowing
		sent = 0;
		sets = 0;
		while (sent < RAND_ITEMS) begin
			calm = (sets >= 6 && sets < 11);
			case ($urandom_range(99)) inside
				[0:7]: len = 1;
				[8:79]: len = $urandom_range(DEPTH, 2);
				[80:91]: len = DEPTH;
				default: len = $urandom_range(DEPTH + 4, DEPTH + 1);
			endcase
			mix = value_mix_e'($urandom_range(3));
			for (int j = 0; j < len; j++) begin
				data_t v;
				v = pick_value(mix);
				push_item(v, j == len - 1);
				sort_step(v, j == len - 1);
			end
			sent += len;
			sets++;
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		// drain, then give the block time to show stray items
		while (pending.size() != 0) @(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
